FILE: rtl/tks_pkg.sv
// ----------------------------------------------------------------------------
// tks_pkg: shared types for the top-K threshold select block
// Beat layouts of the item and result channels and the operation codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tks_pkg;

    localparam int SCORE_W = 32;
    localparam int ENTRY_W = 12;
    localparam int COUNT_W = 13;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic               op;
        logic [SCORE_W-1:0] score;
        logic [ENTRY_W-1:0] entry_index;
        logic               last_load;
    } tks_item_t;

    typedef struct packed {
        logic               selected;
        logic [ENTRY_W-1:0] query_index;
        logic               answer_valid;
    } tks_result_t;

endpackage

`default_nettype wire

FILE: rtl/tks_ram.sv
// ----------------------------------------------------------------------------
// tks_ram: simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tks_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/top_k_threshold_select_top.sv
// ----------------------------------------------------------------------------
// top_k_threshold_select_top: top-K membership test over a stored score run
// Loads a run of scores into a RAM and answers, per query, whether the named
// entry is among the K largest (ties included) by a serial compare sweep.
// ----------------------------------------------------------------------------
// Sequence: a load yields no result beat. A query for a loaded entry passes
//   through ST_MINE, a sweep in ST_SCAN over the loaded count and ST_FINISH;
//   a query past the loaded count goes from ST_IDLE straight to ST_FINISH.
// Throughput: one load per cycle while idle; a query blocks new items until its
//   result is registered, the sweep reading the RAM at one read per cycle via its
//   single read port; a result beat held back by the receiver stalls the input.
// Reset: rst_n clears pointers, count, K and the result flag; RAM left as is.
`default_nettype none

module top_k_threshold_select_top #(
    parameter int MAX_ENTRIES = 4096,
    parameter int SCORE_BITS  = 32
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // configuration: K
    input  wire logic                      cfg_we,
    input  wire logic [tks_pkg::COUNT_W-1:0] cfg_wdata,
    // item channel
    input  wire logic                      item_valid,
    output logic                           item_ready,
    input  wire tks_pkg::tks_item_t        item,
    // result channel
    output logic                           result_valid,
    input  wire logic                      result_ready,
    output tks_pkg::tks_result_t           result
);

    import tks_pkg::*;

    // AW addresses the RAM, CW holds a count up to MAX_ENTRIES itself.
    localparam int AW   = $clog2(MAX_ENTRIES);
    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int IW   = (CW > ENTRY_W) ? CW : ENTRY_W;
    localparam int GW   = (CW > COUNT_W) ? CW : COUNT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MINE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        wp_reg, wp_next;
    logic [CW-1:0]        lc_reg, lc_next;
    logic [CW-1:0]        scan_addr_reg, scan_addr_next;
    logic [CW-1:0]        greater_reg, greater_next;
    logic [COUNT_W-1:0]   select_count_reg;
    logic                 result_valid_reg, result_valid_next;
    tks_result_t          result_reg, result_next;

    logic [SCORE_BITS-1:0] mine_reg;
    logic [ENTRY_W-1:0]    query_idx_reg, query_idx_next;
    logic                  query_ok_reg, query_ok_next;

    logic [CW-1:0]         wp_inc;
    logic                  idx_ok;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [SCORE_BITS-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [SCORE_BITS-1:0] ram_rdata;

    tks_ram #(
        .WIDTH (SCORE_BITS),
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Only entries of the last completed run may be queried.
    assign idx_ok = (IW'(item.entry_index) < IW'(lc_reg));

    always_comb
    begin
        state_next        = state_reg;
        wp_next           = wp_reg;
        lc_next           = lc_reg;
        scan_addr_next    = scan_addr_reg;
        greater_next      = greater_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        query_idx_next    = query_idx_reg;
        query_ok_next     = query_ok_reg;
        wp_inc            = wp_reg;
        ram_we            = 1'b0;
        ram_waddr         = wp_reg[AW-1:0];
        ram_wdata         = SCORE_BITS'(item.score);
        ram_raddr         = scan_addr_reg[AW-1:0];

        // Drop the result beat once taken.
        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                // Present the queried entry so its score lands in the next cycle.
                ram_raddr = AW'(item.entry_index);
                if (item_valid)
                begin
                    if (item.op == OP_LOAD)
                    begin
                        // A fresh run invalidates the previous one.
                        if (wp_reg == '0)
                        begin
                            lc_next = '0;
                        end
                        // Store full: hold the pointer, drop the score.
                        if (wp_reg < CW'(MAX_ENTRIES))
                        begin
                            ram_we = 1'b1;
                            wp_inc = wp_reg + CW'(1);
                        end
                        wp_next = wp_inc;
                        if (item.last_load)
                        begin
                            lc_next = wp_inc;
                            wp_next = '0;
                        end
                    end
                    else
                    begin
                        query_idx_next = item.entry_index;
                        query_ok_next  = idx_ok;
                        greater_next   = '0;
                        state_next     = idx_ok ? ST_MINE : ST_FINISH;
                    end
                end
            end

            ST_MINE:
            begin
                // Queried score is in ram_rdata; start the sweep at entry zero.
                ram_raddr      = '0;
                scan_addr_next = CW'(1);
                state_next     = ST_SCAN;
            end

            ST_SCAN:
            begin
                // ram_rdata holds the entry issued in the previous cycle.
                if (ram_rdata > mine_reg)
                begin
                    greater_next = greater_reg + CW'(1);
                end
                if (scan_addr_reg == lc_reg)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    ram_raddr      = scan_addr_reg[AW-1:0];
                    scan_addr_next = scan_addr_reg + CW'(1);
                end
            end

            ST_FINISH:
            begin
                // Hold until the output register is free.
                if (!result_valid_reg || result_ready)
                begin
                    result_valid_next        = 1'b1;
                    result_next.selected     = query_ok_reg &&
                                               (GW'(greater_reg) < GW'(select_count_reg));
                    result_next.query_index  = query_idx_reg;
                    result_next.answer_valid = query_ok_reg;
                    state_next               = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            wp_reg           <= '0;
            lc_reg           <= '0;
            scan_addr_reg    <= '0;
            greater_reg      <= '0;
            select_count_reg <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            wp_reg           <= wp_next;
            lc_reg           <= lc_next;
            scan_addr_reg    <= scan_addr_next;
            greater_reg      <= greater_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
            if (cfg_we)
            begin
                select_count_reg <= cfg_wdata;
            end
        end
    end

    // Query payload: no reset needed.
    always_ff @(posedge clk)
    begin
        query_idx_reg <= query_idx_next;
        query_ok_reg  <= query_ok_next;
        if (state_reg == ST_MINE)
        begin
            mine_reg <= ram_rdata;
        end
    end

    // A selected answer is always a valid one.
    a_sel_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (!result.selected || result.answer_valid))
        else $error("selected set on an invalid answer");

    // The sweep never runs past the loaded run.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_addr_reg <= lc_reg && lc_reg != '0))
        else $error("sweep address beyond loaded count");

    // The greater count cannot outrun the entries already compared.
    a_greater_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (greater_reg < scan_addr_reg))
        else $error("greater count exceeds compared entries");

    // An accepted query blocks the item channel in the next cycle.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && item.op == OP_QUERY) |=> !item_ready)
        else $error("item accepted while a query is in progress");

    // The write pointer never passes the store depth.
    a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg <= CW'(MAX_ENTRIES))
        else $error("write pointer beyond store depth");

endmodule

`default_nettype wire
